>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define CBSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked on every rising edge, reset included
`define CBSP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

>>> hdl/cbsp_pkg.sv
// ----------------------------------------------------------------------------
// cbsp_pkg
// shared types, constants and the band angle table of the steering picker
// ----------------------------------------------------------------------------
`default_nettype none

package cbsp_pkg;

   localparam int NUM_BANDS        = 5;
   localparam int BAND_CODE_W      = 3;
   localparam int TALLY_W          = 16;
   localparam int ANGLE_W          = 6;
   localparam int DEF_BAND_WIDTH   = 128;
   localparam int DEF_COUNTED_ROWS = 480;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [BAND_CODE_W-1:0] BAND_LEFT    = 3'd0;
   localparam logic [BAND_CODE_W-1:0] BAND_LEFTMID = 3'd1;
   localparam logic [BAND_CODE_W-1:0] BAND_CENTRE  = 3'd2;
   localparam logic [BAND_CODE_W-1:0] BAND_RIGHTMID = 3'd3;
   localparam logic [BAND_CODE_W-1:0] BAND_RIGHT   = 3'd4;
   localparam logic [BAND_CODE_W-1:0] BAND_OUTSIDE = 3'd5;

   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   // floor(9c/10) = c - floor((c+9)/10), the quotient by reciprocal 52429 / 2^19
   localparam int            RECIP_SHIFT = 19;
   localparam int            SUM_W       = TALLY_W + 1;
   localparam int            PROD_W      = SUM_W + TALLY_W;
   localparam logic [15:0]   RECIP_TEN   = 16'd52429;
   localparam logic [SUM_W-1:0] ROUND_UP = 17'd9;

   localparam logic [7:0] CHAN_MAX = 8'd255;
   localparam logic [7:0] CHAN_MIN = 8'd0;

   typedef struct packed {
      logic                   obstacle;
      logic [BAND_CODE_W-1:0] band;
      logic                   end_of_frame;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic signed [ANGLE_W-1:0] band_angle(
      input logic [BAND_CODE_W-1:0] band);
      logic signed [ANGLE_W-1:0] angle;
      case (band)
         BAND_LEFT:     angle = -6'sd20;
         BAND_LEFTMID:  angle = -6'sd10;
         BAND_CENTRE:   angle = 6'sd0;
         BAND_RIGHTMID: angle = 6'sd10;
         BAND_RIGHT:    angle = 6'sd20;
         default:       angle = 6'sd0;
      endcase
      return angle;
   endfunction

endpackage

`default_nettype wire

>>> hdl/column_band_steering_picker_top.sv
// ----------------------------------------------------------------------------
// column_band_steering_picker_top
// counts obstacle pixels in five column bands and picks a steering band
// ----------------------------------------------------------------------------
// one pixel word accepted per clock, sustained while req_stall is low, frame after frame
// after its end of frame word is accepted, a result passes the queue, frame totals,
// reciprocal multiply, pair minima and minimum search registers to rsp_valid
// req_stall rises only when the four entry queue is full behind a stalled result
// synchronous active high reset clears position, tallies, queue and drive speed
// ----------------------------------------------------------------------------
`default_nettype none

module column_band_steering_picker_top #(
   parameter int BAND_WIDTH   = cbsp_pkg::DEF_BAND_WIDTH,
   parameter int COUNTED_ROWS = cbsp_pkg::DEF_COUNTED_ROWS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // pixel words in raster order
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [7:0]                            req_blue,
   input  wire logic [7:0]                            req_green,
   input  wire logic [7:0]                            req_red,
   input  wire logic                                  req_end_of_line,
   input  wire logic                                  req_end_of_frame,
   // one result word per frame
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cbsp_pkg::ANGLE_W-1:0]        rsp_steer_angle,
   output logic [cbsp_pkg::BAND_CODE_W-1:0]           rsp_chosen_band,
   // drive speed register
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic signed [15:0]                    csr_drive_speed
);

   logic                accept;
   logic                queue_full;
   logic                pop;
   cbsp_pkg::entry_type entry;
   cbsp_pkg::head_type  head;
   logic signed [15:0]  speed_ff, speed_in;

   // the queue decouples pixel intake from a stalled result side
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // register write is always taken
   assign csr_ready = 1'b1;
   assign speed_in  = csr_valid ? csr_drive_speed : speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else begin
         speed_ff <= speed_in;
      end
   end

   // front: raster position and obstacle test
   cbsp_front #(
      .BAND_WIDTH   (BAND_WIDTH),
      .COUNTED_ROWS (COUNTED_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .blue         (req_blue),
      .green        (req_green),
      .red          (req_red),
      .end_of_line  (req_end_of_line),
      .end_of_frame (req_end_of_frame),
      .entry        (entry)
   );

   // classified words wait here while the back end is held
   cbsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full)
   );

   // back: tallies and the end of frame decision pipeline
   cbsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .speed_zero      (speed_ff == 16'sd0),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_steer_angle (rsp_steer_angle),
      .rsp_chosen_band (rsp_chosen_band)
   );

endmodule

`default_nettype wire

>>> hdl/cbsp_front.sv
// ----------------------------------------------------------------------------
// cbsp_front
// tracks the raster position and classifies each pixel word for the tallies
// ----------------------------------------------------------------------------
`default_nettype none

module cbsp_front #(
   parameter int BAND_WIDTH   = cbsp_pkg::DEF_BAND_WIDTH,
   parameter int COUNTED_ROWS = cbsp_pkg::DEF_COUNTED_ROWS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          blue,
   input  wire logic [7:0]          green,
   input  wire logic [7:0]          red,
   input  wire logic                end_of_line,
   input  wire logic                end_of_frame,
   output cbsp_pkg::entry_type      entry
);

   localparam int CW = (BAND_WIDTH > 1) ? $clog2(BAND_WIDTH) : 1;
   localparam int RW = $clog2(COUNTED_ROWS + 1);
   localparam logic [CW-1:0] COL_LAST = CW'(BAND_WIDTH - 1);
   localparam logic [RW-1:0] ROW_STOP = RW'(COUNTED_ROWS);

   logic [CW-1:0]                    col_ff, col_in;
   logic [cbsp_pkg::BAND_CODE_W-1:0] band_ff, band_in;
   logic [RW-1:0]                    row_ff, row_in;
   logic                             is_blue, is_black;

   always_comb begin
      is_blue  = (blue == cbsp_pkg::CHAN_MAX) && (green == cbsp_pkg::CHAN_MIN)
                 && (red == cbsp_pkg::CHAN_MIN);
      is_black = (blue == cbsp_pkg::CHAN_MIN) && (green == cbsp_pkg::CHAN_MIN)
                 && (red == cbsp_pkg::CHAN_MIN);
      entry.obstacle     = !is_blue && !is_black && (row_ff < ROW_STOP)
                           && (band_ff != cbsp_pkg::BAND_OUTSIDE);
      entry.band         = band_ff;
      entry.end_of_frame = end_of_frame;
   end

   // band code sticks at outside once past the last band
   always_comb begin
      col_in  = col_ff;
      band_in = band_ff;
      row_in  = row_ff;
      if (accept) begin
         if (end_of_frame) begin
            col_in  = '0;
            band_in = cbsp_pkg::BAND_LEFT;
            row_in  = '0;
         end else if (end_of_line) begin
            col_in  = '0;
            band_in = cbsp_pkg::BAND_LEFT;
            if (row_ff != ROW_STOP) row_in = row_ff + 1'b1;
         end else if (band_ff != cbsp_pkg::BAND_OUTSIDE) begin
            if (col_ff == COL_LAST) begin
               col_in  = '0;
               band_in = band_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         band_ff <= cbsp_pkg::BAND_LEFT;
         row_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         band_ff <= band_in;
         row_ff  <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cbsp_queue.sv
// ----------------------------------------------------------------------------
// cbsp_queue
// short fifo of classified pixel words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cbsp_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  cbsp_pkg::entry_type push_entry,
   input  wire logic          pop,
   output cbsp_pkg::head_type head,
   output logic               full
);

   localparam int PW = $clog2(cbsp_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(cbsp_pkg::QUEUE_DEPTH + 1);
   localparam logic [NW-1:0] DEPTH_N = NW'(cbsp_pkg::QUEUE_DEPTH);

   cbsp_pkg::entry_type slot_ff [cbsp_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0] count_ff, count_in;

   always_comb begin
      head.valid = (count_ff != '0);
      head.entry = slot_ff[rd_ff];
      full       = (count_ff == DEPTH_N);
      wr_in      = push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = pop ? rd_ff + 1'b1 : rd_ff;
      count_in   = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

>>> hdl/cbsp_back.sv
// ----------------------------------------------------------------------------
// cbsp_back
// band tallies, end of frame scaling and minimum search, result register
// ----------------------------------------------------------------------------
`default_nettype none

module cbsp_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  cbsp_pkg::head_type                         head,
   output logic                                       pop,
   input  wire logic                                  speed_zero,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cbsp_pkg::ANGLE_W-1:0]        rsp_steer_angle,
   output logic [cbsp_pkg::BAND_CODE_W-1:0]           rsp_chosen_band
);

   localparam int TW = cbsp_pkg::TALLY_W;
   localparam int NB = cbsp_pkg::NUM_BANDS;
   localparam int QW = cbsp_pkg::PROD_W - cbsp_pkg::RECIP_SHIFT;

   logic [TW-1:0] tally_ff [NB];
   logic [TW-1:0] tally_in [NB];
   logic [TW-1:0] fin      [NB];

   // stage 1: frame totals, stage 2: reciprocal product, stage 3: pair minima
   logic          s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic          rsp_v_ff, rsp_v_in;
   logic [TW-1:0] cnt1_ff [NB];
   logic [TW-1:0] cnt2_ff [NB];
   logic [cbsp_pkg::PROD_W-1:0] prod2_ff, prod_in;
   logic [cbsp_pkg::SUM_W-1:0]  c2_sum;
   logic [QW-1:0]               quot;
   logic [TW-1:0] m01_ff, m34_ff, scaled_ff, m01_in, m34_in, scaled_in;
   logic [cbsp_pkg::BAND_CODE_W-1:0] b01_ff, b34_ff, b01_in, b34_in;
   logic [TW-1:0]                    best_m;
   logic [cbsp_pkg::BAND_CODE_W-1:0] best_b;
   logic signed [cbsp_pkg::ANGLE_W-1:0] angle_ff, angle_in;
   logic [cbsp_pkg::BAND_CODE_W-1:0]    band_ff;
   logic out_ready, s3_ready, s2_ready, s1_ready, frame_pop;

   always_comb begin
      out_ready = !rsp_v_ff || !rsp_stall;
      s3_ready  = !s3_v_ff || out_ready;
      s2_ready  = !s2_v_ff || s3_ready;
      s1_ready  = !s1_v_ff || s2_ready;
      pop       = head.valid && (!head.entry.end_of_frame || s1_ready);
      frame_pop = pop && head.entry.end_of_frame;
   end

   // saturating tally update, cleared as the frame closes
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         fin[i] = tally_ff[i];
         if (head.entry.obstacle && (head.entry.band == cbsp_pkg::BAND_CODE_W'(i))
             && (tally_ff[i] != cbsp_pkg::TALLY_MAX))
            fin[i] = tally_ff[i] + 1'b1;
         tally_in[i] = tally_ff[i];
         if (pop) tally_in[i] = head.entry.end_of_frame ? '0 : fin[i];
      end
   end

   always_comb begin
      s1_v_in  = s1_ready ? frame_pop : s1_v_ff;
      s2_v_in  = s2_ready ? s1_v_ff : s2_v_ff;
      s3_v_in  = s3_ready ? s2_v_ff : s3_v_ff;
      rsp_v_in = out_ready ? s3_v_ff : rsp_v_ff;
   end

   always_comb begin
      c2_sum  = {1'b0, cnt1_ff[cbsp_pkg::BAND_CENTRE]} + cbsp_pkg::ROUND_UP;
      prod_in = cbsp_pkg::PROD_W'(c2_sum) * cbsp_pkg::PROD_W'(cbsp_pkg::RECIP_TEN);
      quot      = prod2_ff[cbsp_pkg::PROD_W-1:cbsp_pkg::RECIP_SHIFT];
      scaled_in = cnt2_ff[cbsp_pkg::BAND_CENTRE] - TW'(quot);
      if (cnt2_ff[cbsp_pkg::BAND_LEFTMID] < cnt2_ff[cbsp_pkg::BAND_LEFT]) begin
         m01_in = cnt2_ff[cbsp_pkg::BAND_LEFTMID];
         b01_in = cbsp_pkg::BAND_LEFTMID;
      end else begin
         m01_in = cnt2_ff[cbsp_pkg::BAND_LEFT];
         b01_in = cbsp_pkg::BAND_LEFT;
      end
      if (cnt2_ff[cbsp_pkg::BAND_RIGHT] < cnt2_ff[cbsp_pkg::BAND_RIGHTMID]) begin
         m34_in = cnt2_ff[cbsp_pkg::BAND_RIGHT];
         b34_in = cbsp_pkg::BAND_RIGHT;
      end else begin
         m34_in = cnt2_ff[cbsp_pkg::BAND_RIGHTMID];
         b34_in = cbsp_pkg::BAND_RIGHTMID;
      end
      // strict compares keep the lower band on a tie
      best_m = m01_ff;
      best_b = b01_ff;
      if (scaled_ff < best_m) begin
         best_m = scaled_ff;
         best_b = cbsp_pkg::BAND_CENTRE;
      end
      if (m34_ff < best_m) best_b = b34_ff;
      angle_in = speed_zero ? '0 : cbsp_pkg::band_angle(best_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) tally_ff[i] <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NB; i++) tally_ff[i] <= tally_in[i];
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && frame_pop) begin
         for (int i = 0; i < NB; i++) cnt1_ff[i] <= fin[i];
      end
      if (s2_ready && s1_v_ff) begin
         for (int i = 0; i < NB; i++) cnt2_ff[i] <= cnt1_ff[i];
         prod2_ff <= prod_in;
      end
      if (s3_ready && s2_v_ff) begin
         m01_ff    <= m01_in;
         b01_ff    <= b01_in;
         m34_ff    <= m34_in;
         b34_ff    <= b34_in;
         scaled_ff <= scaled_in;
      end
      if (out_ready && s3_v_ff) begin
         angle_ff <= angle_in;
         band_ff  <= best_b;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_steer_angle = angle_ff;
   assign rsp_chosen_band = band_ff;

endmodule

`default_nettype wire

>>> hdl/cbsp_checker.sv
// ----------------------------------------------------------------------------
// cbsp_checker
// port level checks on the result channel of the steering picker
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbsp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic signed [5:0] rsp_steer_angle,
   input wire logic [2:0]        rsp_chosen_band
);

   `CBSP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_steer_angle) && $stable(rsp_chosen_band))
   `CBSP_ASSERT(a_band_range, clock, reset, rsp_valid |-> rsp_chosen_band <= 3'd4)
   `CBSP_ASSERT(a_angle_match, clock, reset, rsp_valid |-> (rsp_steer_angle == 6'sd0) || (rsp_chosen_band == 3'd0 && rsp_steer_angle == -6'sd20) || (rsp_chosen_band == 3'd1 && rsp_steer_angle == -6'sd10) || (rsp_chosen_band == 3'd3 && rsp_steer_angle == 6'sd10) || (rsp_chosen_band == 3'd4 && rsp_steer_angle == 6'sd20))
   `CBSP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind column_band_steering_picker_top cbsp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_steer_angle (rsp_steer_angle),
   .rsp_chosen_band (rsp_chosen_band)
);

`default_nettype wire
